// ===== rtl/sclt_pkg.sv =====
package sclt_pkg;

  localparam int KIND_W = 3;
  localparam int CHAR_W = 8;
  localparam int FD_W = 10;
  localparam int ERR_W = 3;
  localparam int MODE_W = 3;
  localparam int MAX_RES = 3;
  localparam int CNT_W = 2;

  localparam logic [KIND_W-1:0] K_BYTE = 3'd0;
  localparam logic [KIND_W-1:0] K_WORD_END = 3'd1;
  localparam logic [KIND_W-1:0] K_REDIR_IN = 3'd2;
  localparam logic [KIND_W-1:0] K_REDIR_OUT = 3'd3;
  localparam logic [KIND_W-1:0] K_REDIR_APP = 3'd4;
  localparam logic [KIND_W-1:0] K_PIPE = 3'd5;
  localparam logic [KIND_W-1:0] K_CMD_END = 3'd6;
  localparam logic [KIND_W-1:0] K_ERROR = 3'd7;

  localparam logic [ERR_W-1:0] E_NONE = 3'd0;
  localparam logic [ERR_W-1:0] E_ESC_END = 3'd1;
  localparam logic [ERR_W-1:0] E_OPEN_SQ = 3'd2;
  localparam logic [ERR_W-1:0] E_OPEN_DQ = 3'd3;
  localparam logic [ERR_W-1:0] E_BAD_BYTE = 3'd4;

  localparam logic [MODE_W-1:0] M_BETWEEN = 3'd0;
  localparam logic [MODE_W-1:0] M_COMMENT = 3'd1;
  localparam logic [MODE_W-1:0] M_WORD = 3'd2;
  localparam logic [MODE_W-1:0] M_WORD_ESC = 3'd3;
  localparam logic [MODE_W-1:0] M_SQ = 3'd4;
  localparam logic [MODE_W-1:0] M_DQ = 3'd5;
  localparam logic [MODE_W-1:0] M_DQ_ESC = 3'd6;
  localparam logic [MODE_W-1:0] M_GT = 3'd7;

  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_HASH = 8'h23;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_AMP = 8'h26;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SEMI = 8'h3b;
  localparam logic [CHAR_W-1:0] CH_LT = 8'h3c;
  localparam logic [CHAR_W-1:0] CH_GT = 8'h3e;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [CHAR_W-1:0] CH_PIPE = 8'h7c;
  localparam logic [CHAR_W-1:0] CH_BAD = 8'hff;

  localparam logic [FD_W-1:0] FD_MAX = 10'd1023;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] data_char;
    logic [FD_W-1:0]   fd_number;
    logic              fd_given;
    logic [ERR_W-1:0]  error_code;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    result_t [MAX_RES-1:0]     res;
  } bundle_t;

endpackage

// ===== rtl/sclt_in_if.sv =====
interface sclt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

// ===== rtl/sclt_out_if.sv =====
interface sclt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] data_char;
  logic [9:0] fd_number;
  logic       fd_given;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output token_kind, output data_char, output fd_number,
                  output fd_given, output error_code, output last, input ready);
  modport sink (input valid, input token_kind, input data_char, input fd_number,
                input fd_given, input error_code, input last, output ready);
endinterface

// ===== rtl/sclt_front.sv =====
module sclt_front (
  input  logic              clk,
  input  logic              rst,
  sclt_in_if.sink           cmd,
  output logic              push_valid,
  output sclt_pkg::bundle_t push_bundle,
  input  logic              push_ready
);

  logic [sclt_pkg::MODE_W-1:0] mode, mode_next;
  logic                        started, started_next;
  logic                        alld, alld_next;
  logic [sclt_pkg::FD_W-1:0]   acc, acc_next;
  logic                        pend, pend_next;

  logic [sclt_pkg::CHAR_W-1:0] c;
  logic [sclt_pkg::CHAR_W-1:0] emit_c;
  logic                        do_ts, do_emit;
  logic [sclt_pkg::CNT_W-1:0]  n;
  logic [13:0]                 prod;
  logic                        accept;

  function automatic sclt_pkg::result_t mk(
    input logic [sclt_pkg::KIND_W-1:0] kind,
    input logic [sclt_pkg::CHAR_W-1:0] data,
    input logic [sclt_pkg::FD_W-1:0]   fd,
    input logic                        given,
    input logic [sclt_pkg::ERR_W-1:0]  err
  );
    sclt_pkg::result_t r;
    r.kind = kind;
    r.data_char = data;
    r.fd_number = fd;
    r.fd_given = given;
    r.error_code = err;
    return r;
  endfunction

  assign accept = cmd.valid && cmd.ready;
  assign cmd.ready = push_ready;
  assign c = cmd.char_code;

  always_comb begin
    mode_next = mode;
    started_next = started;
    alld_next = alld;
    acc_next = acc;
    pend_next = pend;
    n = '0;
    push_bundle = '0;
    do_ts = 1'b0;
    do_emit = 1'b0;
    emit_c = c;
    prod = '0;

    if (cmd.end_of_input) begin
      case (mode)
        sclt_pkg::M_WORD: begin
          push_bundle.res[n] = mk(sclt_pkg::K_WORD_END, '0, '0, 1'b0, sclt_pkg::E_NONE);
          n = n + 2'd1;
        end
        sclt_pkg::M_WORD_ESC, sclt_pkg::M_DQ_ESC, sclt_pkg::M_SQ, sclt_pkg::M_DQ: begin
          if (mode == sclt_pkg::M_SQ) begin
            push_bundle.res[n] = mk(sclt_pkg::K_ERROR, '0, '0, 1'b0, sclt_pkg::E_OPEN_SQ);
          end else if (mode == sclt_pkg::M_DQ) begin
            push_bundle.res[n] = mk(sclt_pkg::K_ERROR, '0, '0, 1'b0, sclt_pkg::E_OPEN_DQ);
          end else begin
            push_bundle.res[n] = mk(sclt_pkg::K_ERROR, '0, '0, 1'b0, sclt_pkg::E_ESC_END);
          end
          n = n + 2'd1;
          push_bundle.res[n] = mk(sclt_pkg::K_WORD_END, '0, '0, 1'b0, sclt_pkg::E_NONE);
          n = n + 2'd1;
        end
        sclt_pkg::M_GT: begin
          push_bundle.res[n] = mk(sclt_pkg::K_REDIR_OUT, '0, pend ? acc : 10'd1, pend,
                                  sclt_pkg::E_NONE);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      push_bundle.res[n] = mk(sclt_pkg::K_CMD_END, '0, '0, 1'b0, sclt_pkg::E_NONE);
      n = n + 2'd1;
      mode_next = sclt_pkg::M_BETWEEN;
      started_next = 1'b0;
      alld_next = 1'b1;
      acc_next = '0;
      pend_next = 1'b0;
    end else begin
      case (mode)
        sclt_pkg::M_COMMENT: begin
          if (c == sclt_pkg::CH_NL) begin
            push_bundle.res[n] = mk(sclt_pkg::K_CMD_END, '0, '0, 1'b0, sclt_pkg::E_NONE);
            n = n + 2'd1;
            push_bundle.res[n] = mk(sclt_pkg::K_CMD_END, '0, '0, 1'b0, sclt_pkg::E_NONE);
            n = n + 2'd1;
            mode_next = sclt_pkg::M_BETWEEN;
          end
        end
        sclt_pkg::M_GT: begin
          push_bundle.res[n] = mk((c == sclt_pkg::CH_GT) ? sclt_pkg::K_REDIR_APP
                                                         : sclt_pkg::K_REDIR_OUT,
                                  '0, pend ? acc : 10'd1, pend, sclt_pkg::E_NONE);
          n = n + 2'd1;
          mode_next = sclt_pkg::M_BETWEEN;
          started_next = 1'b0;
          alld_next = 1'b1;
          acc_next = '0;
          pend_next = 1'b0;
          do_ts = (c != sclt_pkg::CH_GT);
        end
        sclt_pkg::M_WORD, sclt_pkg::M_WORD_ESC, sclt_pkg::M_SQ, sclt_pkg::M_DQ,
        sclt_pkg::M_DQ_ESC: begin
          if (c == sclt_pkg::CH_BAD) begin
            push_bundle.res[n] = mk(sclt_pkg::K_ERROR, '0, '0, 1'b0, sclt_pkg::E_BAD_BYTE);
            n = n + 2'd1;
          end else if (mode == sclt_pkg::M_WORD) begin
            if (c == sclt_pkg::CH_SPACE || c == sclt_pkg::CH_TAB || c == sclt_pkg::CH_CR ||
                c == sclt_pkg::CH_NL || c == sclt_pkg::CH_SEMI || c == sclt_pkg::CH_LT ||
                c == sclt_pkg::CH_GT || c == sclt_pkg::CH_PIPE || c == sclt_pkg::CH_AMP) begin
              started_next = 1'b0;
              if ((c == sclt_pkg::CH_LT || c == sclt_pkg::CH_GT) && alld) begin
                if (c == sclt_pkg::CH_LT) begin
                  push_bundle.res[n] = mk(sclt_pkg::K_REDIR_IN, '0, pend ? acc : 10'd0, pend,
                                          sclt_pkg::E_NONE);
                  n = n + 2'd1;
                  mode_next = sclt_pkg::M_BETWEEN;
                  alld_next = 1'b1;
                  acc_next = '0;
                  pend_next = 1'b0;
                end else begin
                  mode_next = sclt_pkg::M_GT;
                end
              end else begin
                push_bundle.res[n] = mk(sclt_pkg::K_WORD_END, '0, '0, 1'b0, sclt_pkg::E_NONE);
                n = n + 2'd1;
                mode_next = sclt_pkg::M_BETWEEN;
                alld_next = 1'b1;
                acc_next = '0;
                pend_next = 1'b0;
                do_ts = 1'b1;
              end
            end else if (c == sclt_pkg::CH_BSLASH) begin
              mode_next = sclt_pkg::M_WORD_ESC;
            end else if (c == sclt_pkg::CH_SQUOTE) begin
              mode_next = sclt_pkg::M_SQ;
            end else if (c == sclt_pkg::CH_DQUOTE) begin
              mode_next = sclt_pkg::M_DQ;
            end else begin
              do_emit = 1'b1;
            end
          end else if (mode == sclt_pkg::M_WORD_ESC) begin
            do_emit = 1'b1;
            mode_next = sclt_pkg::M_WORD;
          end else if (mode == sclt_pkg::M_SQ) begin
            if (c == sclt_pkg::CH_SQUOTE) begin
              mode_next = sclt_pkg::M_WORD;
            end else begin
              do_emit = 1'b1;
            end
          end else if (mode == sclt_pkg::M_DQ) begin
            if (c == sclt_pkg::CH_DQUOTE) begin
              mode_next = sclt_pkg::M_WORD;
            end else if (c == sclt_pkg::CH_BSLASH) begin
              mode_next = sclt_pkg::M_DQ_ESC;
            end else begin
              do_emit = 1'b1;
            end
          end else begin
            if (c != sclt_pkg::CH_BSLASH && c != sclt_pkg::CH_DQUOTE &&
                c != sclt_pkg::CH_DOLLAR) begin
              push_bundle.res[n] = mk(sclt_pkg::K_BYTE, sclt_pkg::CH_BSLASH, '0, 1'b0,
                                      sclt_pkg::E_NONE);
              n = n + 2'd1;
              alld_next = 1'b0;
              pend_next = 1'b1;
            end
            do_emit = 1'b1;
            mode_next = sclt_pkg::M_DQ;
          end
        end
        default: begin
          mode_next = sclt_pkg::M_BETWEEN;
          do_ts = 1'b1;
        end
      endcase
    end

    if (do_ts) begin
      case (c)
        sclt_pkg::CH_SPACE, sclt_pkg::CH_TAB, sclt_pkg::CH_CR: begin
        end
        sclt_pkg::CH_HASH: begin
          mode_next = sclt_pkg::M_COMMENT;
        end
        sclt_pkg::CH_NL, sclt_pkg::CH_SEMI: begin
          push_bundle.res[n] = mk(sclt_pkg::K_CMD_END, '0, '0, 1'b0, sclt_pkg::E_NONE);
          n = n + 2'd1;
        end
        sclt_pkg::CH_LT: begin
          push_bundle.res[n] = mk(sclt_pkg::K_REDIR_IN, '0, '0, 1'b0, sclt_pkg::E_NONE);
          n = n + 2'd1;
        end
        sclt_pkg::CH_GT: begin
          started_next = 1'b0;
          alld_next = 1'b1;
          acc_next = '0;
          pend_next = 1'b0;
          mode_next = sclt_pkg::M_GT;
        end
        sclt_pkg::CH_PIPE: begin
          push_bundle.res[n] = mk(sclt_pkg::K_PIPE, '0, '0, 1'b0, sclt_pkg::E_NONE);
          n = n + 2'd1;
        end
        sclt_pkg::CH_AMP, sclt_pkg::CH_BAD: begin
          push_bundle.res[n] = mk(sclt_pkg::K_ERROR, '0, '0, 1'b0, sclt_pkg::E_BAD_BYTE);
          n = n + 2'd1;
        end
        default: begin
          started_next = 1'b1;
          alld_next = 1'b1;
          acc_next = '0;
          pend_next = 1'b0;
          if (c == sclt_pkg::CH_BSLASH) begin
            mode_next = sclt_pkg::M_WORD_ESC;
          end else if (c == sclt_pkg::CH_SQUOTE) begin
            mode_next = sclt_pkg::M_SQ;
          end else if (c == sclt_pkg::CH_DQUOTE) begin
            mode_next = sclt_pkg::M_DQ;
          end else begin
            mode_next = sclt_pkg::M_WORD;
            do_emit = 1'b1;
          end
        end
      endcase
    end

    if (do_emit) begin
      push_bundle.res[n] = mk(sclt_pkg::K_BYTE, emit_c, '0, 1'b0, sclt_pkg::E_NONE);
      n = n + 2'd1;
      if (emit_c >= sclt_pkg::CH_ZERO && emit_c <= sclt_pkg::CH_NINE && alld_next) begin
        prod = {4'b0, acc_next} * 14'd10 + {10'b0, emit_c[3:0]};
        acc_next = (prod > {4'b0, sclt_pkg::FD_MAX}) ? sclt_pkg::FD_MAX : prod[9:0];
      end else begin
        alld_next = 1'b0;
      end
      pend_next = 1'b1;
    end

    push_bundle.cnt = n;
  end

  assign push_valid = accept && (n != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sclt_pkg::M_BETWEEN;
      started <= 1'b0;
      alld <= 1'b1;
      acc <= '0;
      pend <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      started <= started_next;
      alld <= alld_next;
      acc <= acc_next;
      pend <= pend_next;
    end
  end

endmodule

// ===== rtl/sclt_queue.sv =====
module sclt_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  sclt_pkg::bundle_t push_bundle,
  output logic              push_ready,
  output logic              head_valid,
  output sclt_pkg::bundle_t head_bundle,
  input  logic              pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sclt_pkg::bundle_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign push_ready = (count != CNT_FULL);
  assign head_valid = (count != '0);
  assign head_bundle = entries[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sclt_back.sv =====
module sclt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  sclt_pkg::bundle_t head_bundle,
  output logic              pop,
  sclt_out_if.source        tok
);

  logic [sclt_pkg::CNT_W-1:0] idx;
  logic                       load, head_last;
  logic                       out_valid, out_last;
  sclt_pkg::result_t          out_res;

  assign load = head_valid && (!out_valid || tok.ready);
  assign head_last = (idx == head_bundle.cnt - 2'd1);
  assign pop = load && head_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx <= head_last ? '0 : idx + 2'd1;
      end else if (tok.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= head_bundle.res[idx];
      out_last <= head_last;
    end
  end

  assign tok.valid = out_valid;
  assign tok.token_kind = out_res.kind;
  assign tok.data_char = out_res.data_char;
  assign tok.fd_number = out_res.fd_number;
  assign tok.fd_given = out_res.fd_given;
  assign tok.error_code = out_res.error_code;
  assign tok.last = out_last;

endmodule

// ===== rtl/shell_command_line_tokenizer.sv =====
// Command-line tokenizer: takes one byte (or an end-of-input mark) per item on cmd and
// gives tokens on tok, with last set on the final token that an item causes. An item
// is taken in the cycle it is offered while the token queue has room; the front stage
// classifies it in that same cycle and queues its tokens (up to three), if any, as one
// group. The output stage sends one token per cycle while tok.ready is high, so input
// runs at one item per cycle as long as each item yields at most one token; an item with
// several tokens holds the output while it sends them one by one, and the queue of
// QUEUE_DEPTH groups absorbs the difference. No clearing pass after reset.
module shell_command_line_tokenizer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  sclt_in_if.sink     cmd,
  sclt_out_if.source  tok
);

  logic              push_valid, push_ready;
  sclt_pkg::bundle_t push_bundle;
  logic              head_valid, pop;
  sclt_pkg::bundle_t head_bundle;

  sclt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .push_valid  (push_valid),
    .push_bundle (push_bundle),
    .push_ready  (push_ready)
  );

  sclt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_valid  (push_valid),
    .push_bundle (push_bundle),
    .push_ready  (push_ready),
    .head_valid  (head_valid),
    .head_bundle (head_bundle),
    .pop         (pop)
  );

  sclt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_bundle (head_bundle),
    .pop         (pop),
    .tok         (tok)
  );

endmodule
